// File: sv/swld_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swld_pkg: shared types and constants for the sync word line deframer
// Phase encoding, result kinds, sync bytes and the result record.
// ----------------------------------------------------------------------------
package swld_pkg;

  localparam logic [7:0] SYNC_FIRST  = 8'h55;
  localparam logic [7:0] SYNC_SECOND = 8'hAA;

  localparam logic [11:0] LINE_WIDTH_RST   = 12'd752;
  localparam logic [11:0] FRAME_HEIGHT_RST = 12'd480;

  localparam int unsigned COORD_W = 12;

  typedef enum logic [0:0] {
    REG_LINE_WIDTH   = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } reg_idx_t;

  typedef enum logic [5:0] {
    PH_HUNT   = 6'b000001,
    PH_ARMED  = 6'b000010,
    PH_ROW_HI = 6'b000100,
    PH_ROW_LO = 6'b001000,
    PH_PIXELS = 6'b010000,
    PH_SKIP   = 6'b100000
  } phase_t;

  typedef enum logic [1:0] {
    KIND_PIXEL     = 2'd0,
    KIND_PIXEL_EOF = 2'd1,
    KIND_FRAME_END = 2'd2,
    KIND_BAD_ROW   = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic [7:0]         pixel;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] column;
  } result_t;

endpackage

// File: sv/swld_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swld_core: line deframing state machine
// Holds config and deframe state; decodes one byte per accepted transaction.
// ----------------------------------------------------------------------------
module swld_core #(
  parameter int unsigned MAX_LINE_WIDTH = 4095
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [0:0]            cfg_addr,
  input  logic [11:0]           cfg_wdata,
  input  logic                  byte_en,
  input  logic [7:0]            byte_in,
  output logic                  res_valid,
  output swld_pkg::result_t     res
);

  localparam int unsigned WCAP_INT = (MAX_LINE_WIDTH > 4095) ? 4095 : MAX_LINE_WIDTH;
  localparam logic [11:0] WCAP     = 12'(WCAP_INT);

  logic [11:0]      line_width_r, frame_height_r;
  swld_pkg::phase_t phase_r, phase_nxt;
  logic [7:0]       row_hi_r, row_hi_nxt;
  logic [15:0]      row_num_r, row_num_nxt;
  logic [11:0]      col_r, col_nxt;

  logic [11:0] width;
  logic [15:0] new_row;
  logic [16:0] fh_plus2;
  logic        hdr_bad, hdr_last, hdr_skip, pix_end, pix_last, skip_end;

  function automatic logic [11:0] sat_row(input logic [15:0] r);
    sat_row = (r > 16'd4095) ? 12'hFFF : r[11:0];
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_width_r   <= swld_pkg::LINE_WIDTH_RST;
      frame_height_r <= swld_pkg::FRAME_HEIGHT_RST;
    end else if (cfg_wr_en) begin
      case (swld_pkg::reg_idx_t'(cfg_addr))
        swld_pkg::REG_LINE_WIDTH:   line_width_r   <= cfg_wdata;
        swld_pkg::REG_FRAME_HEIGHT: frame_height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign width    = (line_width_r > WCAP) ? WCAP : line_width_r;
  assign new_row  = {row_hi_r, byte_in};
  assign fh_plus2 = {5'd0, frame_height_r} + 17'd2;
  assign hdr_bad  = {1'b0, new_row} > fh_plus2;
  assign hdr_last = ({1'b0, new_row} + 17'd1) >= {5'd0, frame_height_r};
  assign hdr_skip = new_row >= {4'd0, frame_height_r};
  assign pix_end  = ({1'b0, col_r} + 13'd1) >= {1'b0, width};
  assign pix_last = ({1'b0, row_num_r} + 17'd1) >= {5'd0, frame_height_r};
  assign skip_end = pix_end;

  always_comb begin
    phase_nxt  = phase_r;
    row_hi_nxt = row_hi_r;
    row_num_nxt = row_num_r;
    col_nxt    = col_r;
    res_valid  = 1'b0;
    res.kind   = swld_pkg::KIND_PIXEL;
    res.pixel  = 8'd0;
    res.row    = sat_row(row_num_r);
    res.column = 12'd0;
    case (phase_r)
      swld_pkg::PH_HUNT, swld_pkg::PH_ARMED: begin
        if (byte_in == swld_pkg::SYNC_FIRST) begin
          phase_nxt = swld_pkg::PH_ARMED;
        end else if (phase_r == swld_pkg::PH_ARMED && byte_in == swld_pkg::SYNC_SECOND) begin
          phase_nxt = swld_pkg::PH_ROW_HI;
        end else begin
          phase_nxt = swld_pkg::PH_HUNT;
        end
      end
      swld_pkg::PH_ROW_HI: begin
        row_hi_nxt = byte_in;
        phase_nxt  = swld_pkg::PH_ROW_LO;
      end
      swld_pkg::PH_ROW_LO: begin
        row_num_nxt = new_row;
        col_nxt     = 12'd0;
        res.row     = sat_row(new_row);
        if (hdr_bad) begin
          phase_nxt = swld_pkg::PH_HUNT;
          res_valid = 1'b1;
          res.kind  = swld_pkg::KIND_BAD_ROW;
        end else if (width == 12'd0) begin
          phase_nxt = swld_pkg::PH_HUNT;
          res_valid = hdr_last;
          res.kind  = swld_pkg::KIND_FRAME_END;
        end else if (hdr_skip) begin
          phase_nxt = swld_pkg::PH_SKIP;
          res_valid = 1'b1;
          res.kind  = swld_pkg::KIND_FRAME_END;
        end else begin
          phase_nxt = swld_pkg::PH_PIXELS;
        end
      end
      swld_pkg::PH_PIXELS: begin
        res_valid  = 1'b1;
        res.pixel  = byte_in;
        res.column = col_r;
        col_nxt    = col_r + 12'd1;
        if (pix_end) begin
          phase_nxt = swld_pkg::PH_HUNT;
          if (pix_last) begin
            res.kind = swld_pkg::KIND_PIXEL_EOF;
          end
        end
      end
      swld_pkg::PH_SKIP: begin
        col_nxt = col_r + 12'd1;
        if (skip_end) begin
          phase_nxt = swld_pkg::PH_HUNT;
        end
      end
      default: begin
        phase_nxt = swld_pkg::PH_HUNT;
      end
    endcase
    if (!byte_en) begin
      res_valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= swld_pkg::PH_HUNT;
      row_hi_r  <= 8'd0;
      row_num_r <= 16'd0;
      col_r     <= 12'd0;
    end else if (byte_en) begin
      phase_r   <= phase_nxt;
      row_hi_r  <= row_hi_nxt;
      row_num_r <= row_num_nxt;
      col_r     <= col_nxt;
    end
  end

endmodule

// File: sv/swld_out_buf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swld_out_buf: two-entry result buffer
// Registers results and takes input during sink stalls while an entry is free.
// ----------------------------------------------------------------------------
module swld_out_buf (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  swld_pkg::result_t push_data,
  output logic              space,
  output logic              out_valid,
  input  logic              out_ready,
  output swld_pkg::result_t out_data
);

  swld_pkg::result_t entry_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r, count_nxt;
  logic       pop;

  assign out_valid = (count_r != 2'd0);
  assign space     = (count_r != 2'd2);
  assign pop       = out_valid && out_ready;
  assign out_data  = entry_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      count_r <= count_nxt;
    end
  end

endmodule

// File: sv/sync_word_line_deframer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sync_word_line_deframer: camera byte stream line deframer
// Finds 0x55 0xAA sync, reads a 16-bit big-endian row and the line's pixels.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one raw byte per transaction (valid/ready).
//   out_* : zero or one result per input byte: pixel with row and column,
//           end-of-frame pixel, frame end without pixel, or bad row header.
//   cfg_* : line_width (index 0) and frame_height (index 1), written while
//           the block is idle; one write per cycle, no read-back.
// Throughput: one byte per cycle while in_ready is high. Each byte is decoded
//   in the cycle it is accepted and its result is registered in a two-entry
//   output buffer, which presents results on out_* in order.
// Stall: in_ready drops only when both buffer entries hold results the sink
//   has not taken; bytes that give no result still need a free entry.
// Reset: synchronous, active low; hunting for sync, buffer empty,
//   line_width 752, frame_height 480.
// ----------------------------------------------------------------------------
module sync_word_line_deframer #(
  parameter int unsigned MAX_LINE_WIDTH = 4095
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_pixel,
  output logic [11:0] out_row,
  output logic [11:0] out_column,
  input  logic        cfg_wr_en,
  input  logic [0:0]  cfg_addr,
  input  logic [11:0] cfg_wdata
);

  logic              in_fire;
  logic              res_valid;
  swld_pkg::result_t res;
  swld_pkg::result_t out_data;

  assign in_fire = in_valid && in_ready;

  swld_core #(
    .MAX_LINE_WIDTH(MAX_LINE_WIDTH)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_wr_en(cfg_wr_en),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata),
    .byte_en  (in_fire),
    .byte_in  (in_byte_in),
    .res_valid(res_valid),
    .res      (res)
  );

  swld_out_buf u_out_buf (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (res_valid),
    .push_data(res),
    .space    (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  assign out_kind   = out_data.kind;
  assign out_pixel  = out_data.pixel;
  assign out_row    = out_data.row;
  assign out_column = out_data.column;

endmodule
